// ===== src/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
// Used by every module under src; depends on nothing else.
package sobel_pkg;

  // Frame size limits and the widths that follow from them
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned HGT_W   = 13;
  localparam int unsigned THR_W   = 11;
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned WSUM_W  = 10;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CIDX_W  = 2;

  // Smallest and largest usable frame dimensions
  localparam logic [WIDTH_W-1:0] MIN_WIDTH  = WIDTH_W'(3);
  localparam logic [HGT_W-1:0]   MIN_HEIGHT = HGT_W'(3);
  localparam logic [WIDTH_W-1:0] CLAMP_W    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0]   CLAMP_H    = HGT_W'(MAX_HEIGHT);

  // Reset values of the configuration registers
  localparam logic [WIDTH_W-1:0] RST_WIDTH  = WIDTH_W'(512);
  localparam logic [HGT_W-1:0]   RST_HEIGHT = HGT_W'(512);
  localparam logic [THR_W-1:0]   RST_THR    = THR_W'(128);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // One column of the 3x3 window, upper row first
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  // Entry of the shared line store: the two previous rows at one column
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  // Position side band carried down the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  // One result request
  typedef struct packed {
    logic             edge_res;
    logic [SUM_W-1:0] gradient_sum;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } res_t;

endpackage

// ===== src/sobel_line_buf.sv =====
// Line store holding the two previous image rows, one entry per column.
// Single write port, single registered read port; uses sobel_pkg.
module sobel_line_buf (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [sobel_pkg::COL_W-1:0]         rd_addr_i,
  output sobel_pkg::line_pair_t               rd_data_o,
  input  logic                                wr_en_i,
  input  logic [sobel_pkg::COL_W-1:0]         wr_addr_i,
  input  sobel_pkg::line_pair_t               wr_data_i
);
  import sobel_pkg::*;

  line_pair_t mem_q [MAX_WIDTH];
  line_pair_t rd_data_q;

  // Write the shifted pair back
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read data; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sobel_win_cell.sv =====
// One column cell of the 3x3 window chain: holds three pixels and hands
// them to its left neighbour on each shift. Uses sobel_pkg.
module sobel_win_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  sobel_pkg::win_col_t   col_i,
  output sobel_pkg::win_col_t   col_o
);
  import sobel_pkg::*;

  win_col_t col_q;

  // Take the neighbour's column on a shift, hold otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== src/sobel_grad.sv =====
// Gradient pipeline: weighted row and column sums, absolute differences,
// then the L1 sum and threshold compare. Uses sobel_pkg.
module sobel_grad (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  sobel_pkg::meta_t               meta_i,
  input  sobel_pkg::win_col_t            left_i,
  input  sobel_pkg::win_col_t            centre_i,
  input  sobel_pkg::win_col_t            right_i,
  input  logic [sobel_pkg::THR_W-1:0]    threshold_i,
  output logic                           valid_o,
  output sobel_pkg::res_t                res_o
);
  import sobel_pkg::*;

  logic [WSUM_W-1:0] top_d, bot_d, lft_d, rgt_d;
  logic [WSUM_W-1:0] top_q, bot_q, lft_q, rgt_q;
  logic              s3_v_q;
  meta_t             s3_meta_q;
  logic [WSUM_W-1:0] ady_d, adx_d, ady_q, adx_q;
  logic              s4_v_q;
  meta_t             s4_meta_q;
  logic [SUM_W-1:0]  sum;

  // Weighted sums of the outer rows and outer columns
  assign top_d = WSUM_W'(left_i.top) + {1'b0, centre_i.top, 1'b0} + WSUM_W'(right_i.top);
  assign bot_d = WSUM_W'(left_i.bot) + {1'b0, centre_i.bot, 1'b0} + WSUM_W'(right_i.bot);
  assign lft_d = WSUM_W'(left_i.top) + {1'b0, left_i.mid, 1'b0} + WSUM_W'(left_i.bot);
  assign rgt_d = WSUM_W'(right_i.top) + {1'b0, right_i.mid, 1'b0} + WSUM_W'(right_i.bot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s3_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q     <= top_d;
      bot_q     <= bot_d;
      lft_q     <= lft_d;
      rgt_q     <= rgt_d;
      s3_meta_q <= meta_i;
    end
  end

  // Absolute differences of the gradient pairs
  assign ady_d = (bot_q > top_q) ? (bot_q - top_q) : (top_q - bot_q);
  assign adx_d = (lft_q > rgt_q) ? (lft_q - rgt_q) : (rgt_q - lft_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ady_q     <= ady_d;
      adx_q     <= adx_d;
      s4_meta_q <= s3_meta_q;
    end
  end

  // L1 magnitude and threshold compare
  assign sum = SUM_W'(ady_q) + SUM_W'(adx_q);

  always_comb begin
    res_o.edge_res     = (sum > threshold_i);
    res_o.gradient_sum = sum;
    res_o.out_row      = s4_meta_q.row;
    res_o.out_col      = s4_meta_q.col;
    res_o.frame_last   = s4_meta_q.last;
  end

  assign valid_o = s4_v_q;

endmodule

// ===== src/sobel_edge_threshold.sv =====
// Top level of the Sobel 3x3 edge detector with L1 magnitude threshold.
// Uses sobel_pkg, sobel_line_buf, sobel_win_cell and sobel_grad.
//
// Usage:
//   Pixels enter in raster order on the in_valid_i / in_ready_o channel,
//   one 8-bit grey value per request. For every pixel that completes a
//   3x3 window around an interior centre (row and column at least 1), one
//   result request leaves on out_valid_o / out_ready_i, carrying the edge
//   flag, |gx| + |gy|, the centre's row and column, and a last-of-frame
//   flag. Border pixels produce no result.
//   Throughput is one pixel per clock while in_ready_o is high. A result
//   passes the line store read at the accepting edge, the window shift,
//   weighted sums, absolute differences and the output register.
//   Configuration (width, height, threshold) is written through
//   cfg_valid_i / cfg_ready_o while the stream is idle; cfg_ready_o is
//   always high. Reset restores 512 x 512 and threshold 128 and starts at
//   row 0, column 0; the line store is not cleared.
//   When the receiver stalls, the output register plus a one-entry skid
//   stage absorb the result in flight, and in_ready_o drops until the
//   skid stage drains.
module sobel_edge_threshold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sobel_pkg::CIDX_W-1:0]      cfg_index_i,
  input  logic [sobel_pkg::CFG_W-1:0]       cfg_data_i,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sobel_pkg::PIX_W-1:0]       pixel_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              edge_res_o,
  output logic [sobel_pkg::SUM_W-1:0]       gradient_sum_o,
  output logic [sobel_pkg::ROW_W-1:0]       out_row_o,
  output logic [sobel_pkg::COL_W-1:0]       out_col_o,
  output logic                              frame_last_o
);
  import sobel_pkg::*;

  // Configuration registers
  logic [WIDTH_W-1:0] width_q;
  logic [HGT_W-1:0]   height_q;
  logic [THR_W-1:0]   thr_q;
  logic [WIDTH_W-1:0] w_eff;
  logic [HGT_W-1:0]   h_eff;

  // Position counters
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic               accept;
  logic               emit;
  meta_t              meta;

  // Pipeline control
  logic               en;
  logic               s1_v_q;
  logic [PIX_W-1:0]   s1_px_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               s1_emit_q;
  meta_t              s1_meta_q;
  logic               s2_v_q;
  meta_t              s2_meta_q;
  line_pair_t         rd_pair;
  line_pair_t         wr_pair;
  logic               shift;
  win_col_t           chain [4];

  // Result path
  logic               grad_v;
  res_t               grad_res;
  logic               out_v_q;
  res_t               out_q;
  logic               skid_v_q;
  res_t               skid_q;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      thr_q    <= RST_THR;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i[HGT_W-1:0];
        CFG_EDGE_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the usable range
  always_comb begin
    if (width_q < MIN_WIDTH) begin
      w_eff = MIN_WIDTH;
    end else if (width_q > CLAMP_W) begin
      w_eff = CLAMP_W;
    end else begin
      w_eff = width_q;
    end
    if (height_q < MIN_HEIGHT) begin
      h_eff = MIN_HEIGHT;
    end else if (height_q > CLAMP_H) begin
      h_eff = CLAMP_H;
    end else begin
      h_eff = height_q;
    end
  end

  // Stall the whole pipeline while the skid stage is occupied
  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Decide emission and position of the centre for this pixel
  always_comb begin
    emit = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
           (HGT_W'(row_q) < h_eff) && (WIDTH_W'(col_q) < w_eff);
    meta.row  = row_q - ROW_W'(1);
    meta.col  = col_q - COL_W'(1);
    meta.last = (HGT_W'(row_q) == h_eff - HGT_W'(1)) &&
                (WIDTH_W'(col_q) == w_eff - WIDTH_W'(1));
  end

  // Advance the raster position with wrap at row and frame end
  always_comb begin
    col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
    row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
    col_d   = col_inc[COL_W-1:0];
    row_d   = row_q;
    if (WIDTH_W'(col_inc) >= w_eff) begin
      col_d = '0;
      if (HGT_W'(row_inc) >= h_eff) begin
        row_d = '0;
      end else begin
        row_d = row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: line store read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_q;
      s1_emit_q <= emit;
      s1_meta_q <= meta;
    end
  end

  // Shift the stored rows up by one at this column
  assign shift          = en && s1_v_q;
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_px_q;

  sobel_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_pair),
    .wr_en_i   (shift),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_pair)
  );

  // Window chain: new column enters on the right, oldest sits at the left
  assign chain[3].top = rd_pair.upper;
  assign chain[3].mid = rd_pair.middle;
  assign chain[3].bot = s1_px_q;

  for (genvar i = 0; i < 3; i++) begin : g_cell
    sobel_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   (chain[i+1]),
      .col_o   (chain[i])
    );
  end

  // Stage 2: window holds the centre's neighbourhood
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  sobel_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s2_v_q),
    .meta_i      (s2_meta_q),
    .left_i      (chain[0]),
    .centre_i    (chain[1]),
    .right_i     (chain[2]),
    .threshold_i (thr_q),
    .valid_o     (grad_v),
    .res_o       (grad_res)
  );

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (grad_v) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (grad_v) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= grad_res;
      end else begin
        out_q <= grad_res;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign edge_res_o     = out_q.edge_res;
  assign gradient_sum_o = out_q.gradient_sum;
  assign out_row_o      = out_q.out_row;
  assign out_col_o      = out_q.out_col;
  assign frame_last_o   = out_q.frame_last;

endmodule
